FILE: hdl/swm_pkg.sv
// swm_pkg: shared types, constants and helpers for the sliding window maximum block.
// No dependencies; imported by every module of the block.
package swm_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int MAX_WINDOW_DEF = 64;
  localparam int CFG_WIDTH      = 7;

  localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = CFG_WIDTH'(3);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           first_sample;
    logic                           last_sample;
  } sample_req_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] window_max;
    logic                           last_window;
  } result_t;

  function automatic sample_t smax(input sample_t a, input sample_t b);
    smax = (a > b) ? a : b;
  endfunction

endpackage

FILE: hdl/sliding_window_maximum_top.sv
// sliding_window_maximum_top: running maximum over the last window_length samples.
// A result is registered and shown in the cycle after its sample request is taken.
// Throughput: one sample per cycle while results are taken; the output register frees in the cycle it is taken.
// Reset (rst, synchronous): window_length back to 3, sample count and output valid cleared.
// The cell row needs no reset: a result is only shown once a full window has gone through it.
// Depends on swm_pkg, swm_chain, swm_cell.
module sliding_window_maximum_top #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // sample request channel
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  swm_pkg::sample_req_t            sample_req,
  // result channel
  output logic                            result_valid,
  input  logic                            result_ready,
  output swm_pkg::result_t                result,
  // window length register
  input  logic                            window_we,
  input  logic [swm_pkg::CFG_WIDTH-1:0]   window_wdata
);
  import swm_pkg::*;

  localparam int IW = $clog2(MAX_WINDOW);
  localparam int NW = $clog2(MAX_WINDOW + 1);
  localparam int CW = (CFG_WIDTH > NW) ? CFG_WIDTH : NW;

  logic [CFG_WIDTH-1:0] window_length;
  logic [CW-1:0]        samples_seen;
  logic [CW-1:0]        samples_seen_next;
  logic [CW-1:0]        wl_ext;
  logic [CW-1:0]        w_eff;
  logic [CW-1:0]        seen_base;
  logic [CW-1:0]        seen_inc;
  logic [IW-1:0]        tap_idx;
  logic                 accept;
  logic                 emit;
  sample_t              tap_max;

  // Window register. A write in the same cycle as reset still lands.
  always_ff @(posedge clk) begin
    if (window_we) begin
      window_length <= window_wdata;
    end else if (rst) begin
      window_length <= WINDOW_RESET;
    end
  end

  // Effective window: zero acts as one, anything past the row length clamps to it.
  assign wl_ext = CW'(window_length);
  always_comb begin
    if (wl_ext == '0) begin
      w_eff = CW'(1);
    end else if (wl_ext > CW'(MAX_WINDOW)) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = wl_ext;
    end
  end
  assign tap_idx = IW'(w_eff - CW'(1));

  // The output register parts the two sides; a new request goes in as the old result leaves.
  assign sample_ready = !rst && (!result_valid || result_ready);
  assign accept       = sample_valid && sample_ready;

  // Samples seen in this sequence, saturating at the window. A first flag restarts it.
  // After a shrink the count drops to the new window; after a growth it has to climb,
  // which also keeps any sample aged out under the old window from reaching a result.
  always_comb begin
    seen_base = sample_req.first_sample ? '0 : samples_seen;
    seen_inc  = (seen_base < w_eff) ? seen_base + CW'(1) : seen_base;
    samples_seen_next = (seen_inc > w_eff) ? w_eff : seen_inc;
  end
  assign emit = (samples_seen_next == w_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
    end else if (accept) begin
      samples_seen <= samples_seen_next;
    end
  end

  // Cell k keeps the max of the last k+1 samples; the tap picks cell w-1 as it updates.
  swm_chain #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_chain (
    .clk    (clk),
    .en     (accept),
    .sample (sample_req.sample),
    .tap_idx(tap_idx),
    .tap_max(tap_max)
  );

  // Output register: valid only when a full window has been seen.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result.window_max  <= tap_max;
      result.last_window <= sample_req.last_sample;
    end
  end

endmodule

FILE: hdl/swm_cell.sv
// swm_cell: one stage of the running-maximum chain.
// Depends on swm_pkg.
module swm_cell (
  input  logic           clk,
  input  logic           en,
  input  swm_pkg::sample_t prev,
  input  swm_pkg::sample_t sample,
  output swm_pkg::sample_t m
);
  import swm_pkg::*;

  // Max of the previous cell's span and the new sample: span grows by one.
  always_ff @(posedge clk) begin
    if (en) begin
      m <= smax(prev, sample);
    end
  end

endmodule

FILE: hdl/swm_chain.sv
// swm_chain: row of swm_cell stages; cell k holds the max of the last k+1 samples.
// Depends on swm_pkg and swm_cell.
module swm_chain #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
  localparam int IW = $clog2(MAX_WINDOW)
) (
  input  logic             clk,
  input  logic             en,
  input  swm_pkg::sample_t sample,
  input  logic [IW-1:0]    tap_idx,
  output swm_pkg::sample_t tap_max
);
  import swm_pkg::*;

  sample_t       m [MAX_WINDOW];
  logic [IW-1:0] prev_idx;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      swm_cell u_cell (.clk(clk), .en(en), .prev(sample), .sample(sample), .m(m[k]));
    end else begin : g_body
      swm_cell u_cell (.clk(clk), .en(en), .prev(m[k-1]), .sample(sample), .m(m[k]));
    end
  end

  // Value cell tap_idx takes on this update, seen ahead of the clock edge.
  assign prev_idx = tap_idx - IW'(1);
  assign tap_max  = (tap_idx == '0) ? sample : smax(m[prev_idx], sample);

endmodule

FILE: hdl/swm_checker.sv
// swm_checker: port-level checks for sliding_window_maximum_top, attached by bind below.
// Depends on swm_pkg and sliding_window_maximum_top.
module swm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_ready,
  input swm_pkg::sample_req_t          sample_req,
  input logic                          result_valid,
  input logic                          result_ready,
  input swm_pkg::result_t              result,
  input logic                          window_we,
  input logic [swm_pkg::CFG_WIDTH-1:0] window_wdata
);
  import swm_pkg::*;

  logic [CFG_WIDTH-1:0] wl_seen;
  logic                 accept;
  logic                 unit_window;

  always_ff @(posedge clk) begin
    if (window_we) begin
      wl_seen <= window_wdata;
    end else if (rst) begin
      wl_seen <= WINDOW_RESET;
    end
  end

  assign accept      = sample_valid && sample_ready;
  assign unit_window = (wl_seen == '0) || (wl_seen == CFG_WIDTH'(1));

  // A held result must not move.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Nothing shows up without a request behind it.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(accept))
    else $error("result appeared without a request");

  // Last flag travels with its own sample.
  a_last: assert property (@(posedge clk) disable iff (rst)
    accept |=> !result_valid || (result.last_window == $past(sample_req.last_sample)))
    else $error("last flag mismatch");

  // Window of one: the result is the sample itself.
  a_unit: assert property (@(posedge clk) disable iff (rst)
    accept && unit_window |=> result_valid && (result.window_max == $past(sample_req.sample)))
    else $error("window of one did not pass the sample");

  // A fresh sequence cannot fill a longer window on its first sample.
  a_short: assert property (@(posedge clk) disable iff (rst)
    accept && sample_req.first_sample && !unit_window |=> !result_valid)
    else $error("result from a short sequence");

endmodule

bind sliding_window_maximum_top swm_checker u_swm_checker (.*);

FILE: sim/sliding_window_maximum_top_tb.sv
// sliding_window_maximum_top_tb: self-checking bench for the running window maximum block.
// Drives sample requests and window_length writes, predicts each maximum with its own deque.
// Depends on swm_pkg and sliding_window_maximum_top from the hdl folder.
`timescale 1ns / 1ps

module sliding_window_maximum_top_tb;
  import swm_pkg::*;

  localparam int DEPTH      = MAX_WINDOW_DEF;
  localparam int IDLE_LIMIT = 2000;   // cycles with no request, result or write taken

  // stimulus value shapes for the random sequences
  typedef enum int unsigned {
    SHAPE_NOISE,
    SHAPE_NARROW,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_EXTREME
  } shape_e;

  // receiver back-pressure patterns
  typedef enum int unsigned {
    RX_OPEN,
    RX_SPARSE,
    RX_PERIODIC,
    RX_COIN
  } rx_mode_e;

  logic                 clk;
  logic                 rst;
  logic                 sample_valid;
  logic                 sample_ready;
  sample_req_t          sample_req;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 window_we;
  logic [CFG_WIDTH-1:0] window_wdata;

  sliding_window_maximum_top uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_req   (sample_req),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .window_we    (window_we),
    .window_wdata (window_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor: monotonic deque of candidates, oldest first, strictly falling
  // values. Ages count requests since the candidate arrived.
  // ---------------------------------------------------------------------------
  sample_t              cand_val [DEPTH];
  int unsigned          cand_age [DEPTH];
  int unsigned          cand_count;
  int unsigned          seq_seen;       // saturates at the effective window
  logic [CFG_WIDTH-1:0] window_shadow;  // mirror of window_length

  result_t              expected_max [$];
  result_t              predicted;
  result_t              wanted;

  int unsigned          samples_taken;
  int unsigned          maxima_checked;
  int unsigned          window_writes;
  int unsigned          mismatches;
  int unsigned          idle_cycles = 0;

  // zero acts as one, anything above the deque depth saturates
  function automatic int unsigned clamp_window(input logic [CFG_WIDTH-1:0] w);
    if (w == '0)
      return 1;
    if (int'(w) > DEPTH)
      return DEPTH;
    return int'(w);
  endfunction

  function automatic bit predict_window_max(input sample_req_t r, output result_t res);
    int unsigned w;
    int unsigned kept;
    int unsigned age;
    int unsigned i;
    sample_t     s;
    w    = clamp_window(window_shadow);
    s    = $signed(r.sample);
    kept = 0;
    res  = '0;
    if (r.first_sample) begin
      cand_count = 0;
      seq_seen   = 0;
    end
    // age, expire and evict anything not strictly above the new sample
    for (i = 0; i < cand_count; i++) begin
      age = cand_age[i];
      if (age < DEPTH)
        age++;
      if (age < w && cand_val[i] > s) begin
        cand_val[kept] = cand_val[i];
        cand_age[kept] = age;
        kept++;
      end
    end
    cand_count = kept;
    if (kept < DEPTH) begin
      cand_val[kept] = s;
      cand_age[kept] = 0;
      cand_count     = kept + 1;
    end
    if (seq_seen < w)
      seq_seen++;
    if (seq_seen > w)
      seq_seen = w;
    if (seq_seen < w)
      return 1'b0;
    res.window_max  = cand_val[0];
    res.last_window = r.last_sample;
    return 1'b1;
  endfunction

  // Mirror of the register and the request side, sampled on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      window_shadow = WINDOW_RESET;
      cand_count    = 0;
      seq_seen      = 0;
    end else begin
      if (window_we)
        window_shadow = window_wdata;
      if (sample_valid && sample_ready) begin
        samples_taken++;
        if (predict_window_max(sample_req, predicted))
          expected_max = {expected_max, predicted};
      end
    end
  end

  // Result checker: every taken result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_max.size() == 0) begin
        $display("%0t: unexpected result, nothing expected, got max %0d last %0b",
                 $time, $signed(result.window_max), result.last_window);
        mismatches++;
      end else begin
        wanted = expected_max[0];
        expected_max.delete(0);
        maxima_checked++;
        if (result.window_max !== wanted.window_max) begin
          $display("%0t: window_max expected %0d got %0d", $time,
                   $signed(wanted.window_max), $signed(result.window_max));
          mismatches++;
        end
        if (result.last_window !== wanted.last_window) begin
          $display("%0t: last_window expected %0b got %0b", $time,
                   wanted.last_window, result.last_window);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: stalled handshakes end the run
  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (result_valid && result_ready) || window_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d maxima outstanding", $time,
               idle_cycles, expected_max.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: back-pressure in stretches, each stretch with its own pattern,
  // open stretches included so full-rate runs happen too.
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 80);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     result_ready <= 1'b1;
      RX_SPARSE:   result_ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: result_ready <= ((rx_tick % 7) < 3);
      default:     result_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender. Entered and left at a falling edge; on return valid is still high
  // so the next call either replaces the request or lowers valid in the same
  // step, never both.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;

  task automatic send_sample(input sample_req_t r);
    if (burst_left == 0) begin
      // most bursts start after a gap, some run straight on
      if ($urandom_range(0, 3) != 0) begin
        sample_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    sample_req   <= r;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready)
      @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic sender_idle();
    sample_valid <= 1'b0;
  endtask

  // wait until every predicted maximum has come back, then wait out requests that produced none
  task automatic drain_results();
    sender_idle();
    while (expected_max.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_window(input logic [CFG_WIDTH-1:0] w);
    drain_results();
    window_we    <= 1'b1;
    window_wdata <= w;
    @(negedge clk);
    window_we    <= 1'b0;
    window_writes++;
  endtask

  function automatic sample_req_t pack_sample(input sample_t v, input bit f, input bit l);
    sample_req_t r;
    r.sample       = v;
    r.first_sample = f;
    r.last_sample  = l;
    return r;
  endfunction

  function automatic sample_t next_sample(input shape_e shape, input sample_t prev);
    case (shape)
      SHAPE_NOISE:   return sample_t'($urandom);
      SHAPE_NARROW:  return sample_t'($urandom_range(0, 6)) - sample_t'(3);  // many ties
      SHAPE_RISING:  return prev + sample_t'($urandom_range(0, 400));
      SHAPE_FALLING: return prev - sample_t'($urandom_range(0, 400));          // deep deque
      default: begin
        case ($urandom_range(0, 4))
          0:       return sample_t'(16'sh7fff);
          1:       return sample_t'(16'sh8000);
          2:       return sample_t'(0);
          3:       return sample_t'(-1);
          default: return sample_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // reset value of window_length (3), full-scale samples, equal values
  task automatic test_reset_window();
    send_sample(pack_sample(16'sh7fff, 1'b1, 1'b0));
    send_sample(pack_sample(16'sh8000, 1'b0, 1'b0));
    send_sample(pack_sample(16'sh0000, 1'b0, 1'b0));
    send_sample(pack_sample(-16'sd1,   1'b0, 1'b0));
    send_sample(pack_sample(-16'sd1,   1'b0, 1'b0));
    send_sample(pack_sample(16'sd5,    1'b0, 1'b1));
  endtask

  // no first flag after a last flag: the sequence just carries on
  task automatic test_sequence_continues();
    send_sample(pack_sample(16'sh8000, 1'b0, 1'b0));
    send_sample(pack_sample(16'sh8000, 1'b0, 1'b1));
  endtask

  // sequences shorter than the window give nothing
  task automatic test_short_sequence();
    send_sample(pack_sample(16'sd100, 1'b1, 1'b0));
    send_sample(pack_sample(16'sd200, 1'b0, 1'b1));
    send_sample(pack_sample(16'sd7,   1'b1, 1'b1));
  endtask

  // zero acts as one; a window of one passes every sample through
  task automatic test_window_limits();
    set_window(7'd0);
    send_sample(pack_sample(16'sd1234, 1'b1, 1'b0));
    send_sample(pack_sample(-16'sd5,   1'b0, 1'b0));
    send_sample(pack_sample(-16'sd5,   1'b0, 1'b1));
    set_window(7'd1);
    send_sample(pack_sample(16'sh7fff, 1'b1, 1'b1));
  endtask

  // shrink mid-sequence drops old candidates and emits at once, then grow
  task automatic test_window_change();
    set_window(7'd5);
    send_sample(pack_sample(16'sd10, 1'b1, 1'b0));
    send_sample(pack_sample(16'sd9,  1'b0, 1'b0));
    send_sample(pack_sample(16'sd8,  1'b0, 1'b0));
    send_sample(pack_sample(16'sd7,  1'b0, 1'b0));
    set_window(7'd2);
    send_sample(pack_sample(16'sd6,  1'b0, 1'b0));
    set_window(7'd8);
    send_sample(pack_sample(16'sd3,  1'b0, 1'b0));
    send_sample(pack_sample(16'sd2,  1'b0, 1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // Random sequences over a series of window settings, extremes included.
  // Mostly well-formed first..last runs; a few lack the first flag, restart
  // halfway or carry a stray last flag. Settings change without a new first
  // flag, so some changes land mid-sequence.
  // ---------------------------------------------------------------------------
  task automatic test_random_streams();
    logic [CFG_WIDTH-1:0] plan [12];
    int unsigned          eff;
    int unsigned          budget;
    int unsigned          seq_len;
    int unsigned          k;
    shape_e               shape;
    sample_t              v;
    bit                   f;
    bit                   l;
    plan = '{7'd1, 7'd0, 7'd2, 7'd64, 7'd3, 7'd127, 7'd7, 7'd4, 7'd0, 7'd16, 7'd5, 7'd65};
    plan[8] = CFG_WIDTH'($urandom_range(1, 127));
    foreach (plan[p]) begin
      set_window(plan[p]);
      eff    = clamp_window(plan[p]);
      budget = (eff >= 32) ? 100 : 32;
      while (budget > 0) begin
        if ($urandom_range(0, 7) == 0)
          seq_len = $urandom_range(1, eff);
        else
          seq_len = $urandom_range(eff, 2 * eff + 6);
        shape = shape_e'($urandom_range(0, 4));
        v     = sample_t'($urandom);
        for (k = 0; k < seq_len && budget > 0; k++) begin
          f = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
          l = (k == seq_len - 1) || ($urandom_range(0, 29) == 0);
          v = next_sample(shape, v);
          send_sample(pack_sample(v, f, l));
          budget--;
        end
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample_req   = '0;
    window_we    = 1'b0;
    window_wdata = '0;
    burst_left   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_window();
    test_sequence_continues();
    test_short_sequence();
    test_window_limits();
    test_window_change();
    test_random_streams();
    drain_results();
    repeat (8) @(negedge clk);

    $display("summary: %0d sample requests, %0d window maxima checked, %0d window writes",
             samples_taken, maxima_checked, window_writes);
    $display("summary: windows 0, 1 and 127 among them, %0d mismatches", mismatches);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
